### rtl/video_register_port_with_scroll_macros.svh
// Assertion macros used by the checker file.
`ifndef VIDEO_REGISTER_PORT_WITH_SCROLL_MACROS_SVH
`define VIDEO_REGISTER_PORT_WITH_SCROLL_MACROS_SVH

// Same-cycle implication, muted in reset.
`define VRP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, muted in reset.
`define VRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define VRP_ASSERT_ALWAYS_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/vrp_pkg.sv
`default_nettype none

package vrp_pkg;

  typedef enum logic [3:0] {
    KIND_READ     = 4'd0,
    KIND_WRITE    = 4'd1,
    KIND_INCX     = 4'd2,
    KIND_INCY     = 4'd3,
    KIND_COPYX    = 4'd4,
    KIND_COPYY    = 4'd5,
    KIND_VBLANK   = 4'd6,
    KIND_CLEAR    = 4'd7,
    KIND_HIT      = 4'd8,
    KIND_OVERFLOW = 4'd9,
    KIND_NMIACK   = 4'd10
  } kind_t;

  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_OAM_ADDR = 3'd3,
    REG_OAM_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } reg_t;

  localparam logic [13:0] PAL_BASE     = 14'h3F00;
  localparam logic [14:0] COPYX_KEEP   = 15'h7BE0;
  localparam logic [14:0] COPYX_TAKE   = 15'h041F;
  localparam logic [4:0]  COARSE_LAST  = 5'd31;
  localparam logic [4:0]  COARSE_Y_END = 5'd29;
  localparam logic [2:0]  FINE_Y_LAST  = 3'd7;
  localparam logic [14:0] FINE_Y_STEP  = 15'h1000;
  localparam logic [14:0] STEP_ROW     = 15'd32;
  localparam logic [14:0] STEP_ONE     = 15'd1;

  typedef struct packed {
    logic [3:0] kind;
    logic [2:0] reg_sel;
    logic [7:0] write_data;
    logic [7:0] mem_data;
    logic       vblank_dot;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [14:0] vram_addr;
    logic        mem_write;
    logic [13:0] mem_write_addr;
    logic [7:0]  mem_write_data;
    logic [2:0]  fine_x;
    logic [7:0]  control;
    logic [7:0]  mask;
    logic        nmi_pending;
  } out_word_t;

  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr;
  } oam_req_t;

  function automatic logic [4:0] pal_slot(input logic [4:0] a);
    logic [4:0] p;
    p = a;
    if (p[4] && (p[1:0] == 2'b00)) begin
      p[4] = 1'b0;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### rtl/vrp_if.sv
`default_nettype none

interface vrp_cmd_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [2:0] reg_sel;
  logic [7:0] write_data;
  logic [7:0] mem_data;
  logic       vblank_dot;

  modport source (output valid, kind, reg_sel, write_data, mem_data, vblank_dot,
                  input ready);
  modport sink (input valid, kind, reg_sel, write_data, mem_data, vblank_dot,
                output ready);
endinterface

interface vrp_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [14:0] vram_addr;
  logic        mem_write;
  logic [13:0] mem_write_addr;
  logic [7:0]  mem_write_data;
  logic [2:0]  fine_x;
  logic [7:0]  control;
  logic [7:0]  mask;
  logic        nmi_pending;

  modport source (output valid, read_data, vram_addr, mem_write, mem_write_addr,
                  mem_write_data, fine_x, control, mask, nmi_pending,
                  input ready);
  modport sink (input valid, read_data, vram_addr, mem_write, mem_write_addr,
                mem_write_data, fine_x, control, mask, nmi_pending,
                output ready);
endinterface

`default_nettype wire

### rtl/vrp_oam.sv
`default_nettype none

module vrp_oam (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire vrp_pkg::oam_req_t req,
  output logic [7:0]             rdata
);

  logic [7:0]   mem [256];
  logic [255:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (req.we) begin
      vld[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // forward a same-cycle write; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      rdata <= '0;
    end else if (req.we && (req.waddr == req.raddr)) begin
      rdata <= req.wdata;
    end else if (vld[req.raddr]) begin
      rdata <= mem[req.raddr];
    end else begin
      rdata <= '0;
    end
  end

endmodule

`default_nettype wire

### rtl/vrp_regs.sv
`default_nettype none

module vrp_regs (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               acc,
  input  wire vrp_pkg::in_word_t  cmd,
  input  wire logic [7:0]         oam_rdata,
  output vrp_pkg::out_word_t      res,
  output vrp_pkg::oam_req_t       oam_req
);

  logic [7:0]  ctrl, ctrl_next;
  logic [7:0]  mask, mask_next;
  logic [2:0]  status, status_next;
  logic [14:0] vaddr, vaddr_next;
  logic [14:0] taddr, taddr_next;
  logic [2:0]  fx, fx_next;
  logic        wtog, wtog_next;
  logic [7:0]  rbuf, rbuf_next;
  logic [7:0]  oidx, oidx_next;
  logic        nmi, nmi_next;
  logic [7:0]  pal [32];

  logic [13:0] a14;
  logic        is_pal;
  logic [4:0]  slot;
  logic [14:0] vstep;
  logic [4:0]  cy;
  logic        nt;
  logic [7:0]  rd;
  logic        mw;
  logic        pal_we;
  logic        oam_we;

  assign a14    = vaddr[13:0];
  assign is_pal = (a14 >= vrp_pkg::PAL_BASE);
  assign slot   = vrp_pkg::pal_slot(a14[4:0]);
  assign vstep  = vaddr + (ctrl[2] ? vrp_pkg::STEP_ROW : vrp_pkg::STEP_ONE);

  always_comb begin
    ctrl_next   = ctrl;
    mask_next   = mask;
    status_next = status;
    vaddr_next  = vaddr;
    taddr_next  = taddr;
    fx_next     = fx;
    wtog_next   = wtog;
    rbuf_next   = rbuf;
    oidx_next   = oidx;
    nmi_next    = nmi;
    rd          = '0;
    mw          = 1'b0;
    pal_we      = 1'b0;
    oam_we      = 1'b0;
    cy          = vaddr[9:5];
    nt          = vaddr[11];
    case (vrp_pkg::kind_t'(cmd.kind))
      vrp_pkg::KIND_READ: begin
        case (vrp_pkg::reg_t'(cmd.reg_sel))
          vrp_pkg::REG_STATUS: begin
            rd = {status, 5'd0};
            if (cmd.vblank_dot) begin
              rd[7]    = 1'b0;
              nmi_next = 1'b0;
            end
            status_next[2] = 1'b0;
            wtog_next      = 1'b0;
          end
          vrp_pkg::REG_OAM_DATA: rd = oam_rdata;
          vrp_pkg::REG_DATA: begin
            rd         = is_pal ? pal[slot] : rbuf;
            rbuf_next  = cmd.mem_data;
            vaddr_next = vstep;
          end
          default: ;
        endcase
      end
      vrp_pkg::KIND_WRITE: begin
        case (vrp_pkg::reg_t'(cmd.reg_sel))
          vrp_pkg::REG_CTRL: begin
            if (!ctrl[7] && cmd.write_data[7] && status[2]) begin
              nmi_next = 1'b1;
            end
            ctrl_next         = cmd.write_data;
            taddr_next[11:10] = cmd.write_data[1:0];
          end
          vrp_pkg::REG_MASK:     mask_next = cmd.write_data;
          vrp_pkg::REG_OAM_ADDR: oidx_next = cmd.write_data;
          vrp_pkg::REG_OAM_DATA: begin
            oam_we    = 1'b1;
            oidx_next = 8'(oidx + 8'd1);
          end
          vrp_pkg::REG_SCROLL: begin
            if (!wtog) begin
              taddr_next[4:0] = cmd.write_data[7:3];
              fx_next         = cmd.write_data[2:0];
            end else begin
              taddr_next = {cmd.write_data[2:0], taddr[11:10], cmd.write_data[7:3],
                            taddr[4:0]};
            end
            wtog_next = ~wtog;
          end
          vrp_pkg::REG_ADDR: begin
            if (!wtog) begin
              taddr_next = {1'b0, cmd.write_data[5:0], taddr[7:0]};
            end else begin
              taddr_next = {taddr[14:8], cmd.write_data};
              vaddr_next = {taddr[14:8], cmd.write_data};
            end
            wtog_next = ~wtog;
          end
          vrp_pkg::REG_DATA: begin
            if (is_pal) begin
              pal_we = 1'b1;
            end else begin
              mw = 1'b1;
            end
            vaddr_next = vstep;
          end
          default: ;
        endcase
      end
      vrp_pkg::KIND_INCX: begin
        if (vaddr[4:0] == vrp_pkg::COARSE_LAST) begin
          vaddr_next = {vaddr[14:11], ~vaddr[10], vaddr[9:5], 5'd0};
        end else begin
          vaddr_next = vaddr + vrp_pkg::STEP_ONE;
        end
      end
      vrp_pkg::KIND_INCY: begin
        if (vaddr[14:12] != vrp_pkg::FINE_Y_LAST) begin
          vaddr_next = vaddr + vrp_pkg::FINE_Y_STEP;
        end else begin
          if (vaddr[9:5] == vrp_pkg::COARSE_Y_END) begin
            cy = '0;
            nt = ~vaddr[11];
          end else if (vaddr[9:5] == vrp_pkg::COARSE_LAST) begin
            cy = '0;
          end else begin
            cy = 5'(vaddr[9:5] + 5'd1);
          end
          vaddr_next = {3'd0, nt, vaddr[10], cy, vaddr[4:0]};
        end
      end
      vrp_pkg::KIND_COPYX: begin
        vaddr_next = (vaddr & vrp_pkg::COPYX_KEEP) | (taddr & vrp_pkg::COPYX_TAKE);
      end
      vrp_pkg::KIND_COPYY: begin
        vaddr_next = (vaddr & vrp_pkg::COPYX_TAKE) | (taddr & vrp_pkg::COPYX_KEEP);
      end
      vrp_pkg::KIND_VBLANK: begin
        status_next[2] = 1'b1;
        if (ctrl[7]) begin
          nmi_next = 1'b1;
        end
      end
      vrp_pkg::KIND_CLEAR:    status_next    = '0;
      vrp_pkg::KIND_HIT:      status_next[1] = 1'b1;
      vrp_pkg::KIND_OVERFLOW: status_next[0] = 1'b1;
      vrp_pkg::KIND_NMIACK:   nmi_next       = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    res.read_data      = rd;
    res.vram_addr      = vaddr_next;
    res.mem_write      = mw;
    res.mem_write_addr = mw ? a14 : 14'd0;
    res.mem_write_data = mw ? cmd.write_data : 8'd0;
    res.fine_x         = fx_next;
    res.control        = ctrl_next;
    res.mask           = mask_next;
    res.nmi_pending    = nmi_next;
  end

  always_comb begin
    oam_req.we    = acc && oam_we;
    oam_req.waddr = oidx;
    oam_req.wdata = cmd.write_data;
    oam_req.raddr = acc ? oidx_next : oidx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl   <= '0;
      mask   <= '0;
      status <= '0;
      vaddr  <= '0;
      taddr  <= '0;
      fx     <= '0;
      wtog   <= 1'b0;
      rbuf   <= '0;
      oidx   <= '0;
      nmi    <= 1'b0;
      for (int i = 0; i < 32; i++) begin
        pal[i] <= '0;
      end
    end else if (acc) begin
      ctrl   <= ctrl_next;
      mask   <= mask_next;
      status <= status_next;
      vaddr  <= vaddr_next;
      taddr  <= taddr_next;
      fx     <= fx_next;
      wtog   <= wtog_next;
      rbuf   <= rbuf_next;
      oidx   <= oidx_next;
      nmi    <= nmi_next;
      if (pal_we) begin
        pal[slot] <= cmd.write_data;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/vrp_skid.sv
`default_nettype none

module vrp_skid (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire vrp_pkg::out_word_t push_word,
  output logic                    ready,
  output logic                    out_valid,
  output vrp_pkg::out_word_t      out_word,
  input  wire logic               out_ready
);

  logic               skid_valid;
  vrp_pkg::out_word_t skid_word;

  assign ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_word <= skid_valid ? skid_word : push_word;
    end else if (push) begin
      skid_word <= push_word;
    end
  end

endmodule

`default_nettype wire

### rtl/video_register_port_with_scroll.sv
// Picture-processor register port with scroll addressing. Each command word is
// a processor register read or write (register number in reg_sel) or a dot event
// from the renderer (coarse X and Y increment, horizontal and vertical copy from
// the temporary address, vblank set, flag clear, hit, overflow, NMI acknowledge),
// and it returns exactly one result word holding the read byte, the current
// address, any external memory write and the live control, mask, fine X and NMI
// state. A word is taken every clock while the buffer has room: the whole update
// sits in one level of logic ahead of the state registers, and a two-deep result
// buffer keeps the command side ready for one more word when the result side
// stalls. Results are registered at the buffer output. Sprite-store reads use a
// prefetched port, so reset needs no clearing pass: the port is ready at once.
`default_nettype none

module video_register_port_with_scroll (
  input wire logic   clk,
  input wire logic   rst,
  vrp_cmd_if.sink    cmd,
  vrp_res_if.source  res
);

  logic               acc;
  logic               in_rdy;
  logic [7:0]         oam_rdata;
  vrp_pkg::in_word_t  cmd_w;
  vrp_pkg::out_word_t step_w;
  vrp_pkg::out_word_t res_w;
  vrp_pkg::oam_req_t  oam_req;

  assign cmd.ready = in_rdy;
  assign acc       = cmd.valid && in_rdy;

  always_comb begin
    cmd_w.kind       = cmd.kind;
    cmd_w.reg_sel    = cmd.reg_sel;
    cmd_w.write_data = cmd.write_data;
    cmd_w.mem_data   = cmd.mem_data;
    cmd_w.vblank_dot = cmd.vblank_dot;
  end

  vrp_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .cmd       (cmd_w),
    .oam_rdata (oam_rdata),
    .res       (step_w),
    .oam_req   (oam_req)
  );

  vrp_oam u_oam (
    .clk   (clk),
    .rst   (rst),
    .req   (oam_req),
    .rdata (oam_rdata)
  );

  vrp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (acc),
    .push_word (step_w),
    .ready     (in_rdy),
    .out_valid (res.valid),
    .out_word  (res_w),
    .out_ready (res.ready)
  );

  assign res.read_data      = res_w.read_data;
  assign res.vram_addr      = res_w.vram_addr;
  assign res.mem_write      = res_w.mem_write;
  assign res.mem_write_addr = res_w.mem_write_addr;
  assign res.mem_write_data = res_w.mem_write_data;
  assign res.fine_x         = res_w.fine_x;
  assign res.control        = res_w.control;
  assign res.mask           = res_w.mask;
  assign res.nmi_pending    = res_w.nmi_pending;

endmodule

`default_nettype wire

### rtl/vrp_check.sv
`default_nettype none

`include "video_register_port_with_scroll_macros.svh"

module vrp_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cmd_valid,
  input wire logic        cmd_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [14:0] vram_addr,
  input wire logic        mem_write,
  input wire logic [13:0] mem_write_addr,
  input wire logic [7:0]  mem_write_data
);

  `VRP_ASSERT_ALWAYS_NEXT(a_rst_empty, rst, !res_valid, "result valid right after reset")
  `VRP_ASSERT_SAME(a_ready_buffer, !cmd_ready, res_valid, "command stalled with no result held")
  `VRP_ASSERT_NEXT(a_accept_result, cmd_valid && cmd_ready, res_valid, "accepted word left no result")
  `VRP_ASSERT_SAME(a_write_quiet, res_valid && !mem_write,
                   (mem_write_addr == 14'd0) && (mem_write_data == 8'd0),
                   "write fields set without a write")
  `VRP_ASSERT_NEXT(a_hold, res_valid && !res_ready, res_valid && $stable(vram_addr), "stalled result changed")

endmodule

bind video_register_port_with_scroll vrp_check u_vrp_check (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .vram_addr      (res.vram_addr),
  .mem_write      (res.mem_write),
  .mem_write_addr (res.mem_write_addr),
  .mem_write_data (res.mem_write_data)
);

`default_nettype wire
